// ----- rtl/esc_pkg.sv -----
// shared types and constants of the encoder step-cycle calibration block
package esc_pkg;

   localparam int POS_W      = 14;
   localparam int STEP_W     = 8;
   localparam int SPR_W      = 9;
   localparam int SUM_W      = 22;
   localparam int VISIT_W    = 8;
   localparam int ANS_W      = 8;
   localparam int CMD_W      = 2;
   localparam int STAT_W     = 2;
   localparam int DIVIDEND_W = 32;
   localparam int DIVISOR_W  = 15;
   localparam int RNG_W      = 15;

   localparam logic [CMD_W-1:0] CMD_START    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RECORD   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FINALIZE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_QUERY    = 2'd3;

   localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STAT_W-1:0] STAT_NOT_CAL   = 2'd1;
   localparam logic [STAT_W-1:0] STAT_EMPTY_BIN = 2'd2;
   localparam logic [STAT_W-1:0] STAT_RANGE     = 2'd3;

   localparam logic [SPR_W-1:0]   SPR_RESET  = 9'd200;
   localparam logic [RNG_W-1:0]   FULL_SCALE = 15'd16384;
   localparam logic [POS_W-1:0]   HALF_SCALE = 14'd8192;
   localparam logic [VISIT_W-1:0] VISIT_MAX  = 8'd255;

   typedef struct packed {
      logic [SUM_W-1:0]   sum;
      logic [VISIT_W-1:0] visits;
   } bin_entry_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

endpackage

// ----- rtl/encoder_step_cycle_calibration.sv -----
// top level of the encoder step-cycle calibration table with command sequencer
// one request in flight: busy stays high until the strobe cycle has passed
// throughput set by the shared bit-serial divider and the single table read port
// reset: synchronous active high, clears sequencer, table valid flag and bin valid bits,
// loads steps per revolution 200; the receiver cannot stall, each strobe lasts one cycle
module encoder_step_cycle_calibration #(
   parameter int MAX_STEP_CYCLES = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [esc_pkg::CMD_W-1:0]   req_cmd,
   input  logic [esc_pkg::STEP_W-1:0]  req_step_index,
   input  logic [esc_pkg::POS_W-1:0]   req_position,
   output logic                        rsp_strobe,
   output logic [esc_pkg::ANS_W-1:0]   rsp_position_in_cycle,
   output logic [esc_pkg::STAT_W-1:0]  rsp_status,
   input  logic                        csr_wr_en,
   input  logic [esc_pkg::SPR_W-1:0]   csr_wr_data
);

   // address of a bin or table entry, and the cycle count (holds the depth itself)
   localparam int AW = (MAX_STEP_CYCLES > 1) ? $clog2(MAX_STEP_CYCLES) : 1;
   localparam int CW = $clog2(MAX_STEP_CYCLES + 1);
   localparam int QUARTER_RESET = int'(esc_pkg::SPR_RESET) / 4;
   localparam int CNT_RESET_I =
      (QUARTER_RESET > MAX_STEP_CYCLES) ? MAX_STEP_CYCLES : QUARTER_RESET;
   localparam logic [CW-1:0] CNT_RESET = CW'(CNT_RESET_I);

   // sequencer states
   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_REC_WR  = 4'd1;
   localparam logic [3:0] ST_FIN_CHK = 4'd2;
   localparam logic [3:0] ST_FIN_DIV = 4'd3;
   localparam logic [3:0] ST_Q_DIVN  = 4'd4;
   localparam logic [3:0] ST_Q_FIRST = 4'd5;
   localparam logic [3:0] ST_Q_STEP  = 4'd6;
   localparam logic [3:0] ST_Q_CMP   = 4'd7;
   localparam logic [3:0] ST_Q_MUL   = 4'd8;
   localparam logic [3:0] ST_Q_DIV   = 4'd9;
   localparam logic [3:0] ST_DONE    = 4'd10;

   logic [3:0]                       state_ff, state_in;
   logic [AW-1:0]                    idx_ff, idx_in;
   logic [AW-1:0]                    bin_addr_ff, bin_addr_in;
   logic [CW-1:0]                    cnt_ff, cnt_in;
   logic [esc_pkg::SPR_W-1:0]        spr_ff, spr_in;
   logic                             table_valid_ff, table_valid_in;
   logic [esc_pkg::POS_W-1:0]        pos_ff, pos_in;
   logic [esc_pkg::STAT_W-1:0]       status_ff, status_in;
   logic [esc_pkg::ANS_W-1:0]        answer_ff, answer_in;
   logic [esc_pkg::RNG_W-1:0]        r_ff, r_in;
   logic [esc_pkg::POS_W-1:0]        cur_ff, cur_in;
   logic [esc_pkg::DIVISOR_W-1:0]    per_ff, per_in;

   logic                             req_accept;
   logic [esc_pkg::STEP_W-3:0]       req_bin;
   logic                             bin_in_range;
   logic [AW-1:0]                    idx_next;
   logic                             last_entry;
   logic [esc_pkg::STEP_W-2:0]       spr_quarter;
   logic [CW-1:0]                    cnt_from_spr;
   logic [esc_pkg::DIVIDEND_W-1:0]   diff;
   logic [esc_pkg::DIVIDEND_W-1:0]   scaled;

   logic                             clear_all;
   logic                             bin_rd_en;
   logic [AW-1:0]                    bin_rd_addr;
   esc_pkg::bin_entry_type           bin_rd_data;
   logic                             bin_wr_en;
   esc_pkg::bin_entry_type           bin_wr_data;
   logic                             table_wr_en;
   logic                             table_rd_en;
   logic [AW-1:0]                    table_rd_addr;
   logic [esc_pkg::POS_W-1:0]        table_rd_data;
   esc_pkg::div_req_type             div_req;
   logic                             div_done;
   logic [esc_pkg::DIVIDEND_W-1:0]   div_quotient;

   esc_bin_store #(
      .DEPTH (MAX_STEP_CYCLES),
      .AW    (AW)
   ) u_bins (
      .clock     (clock),
      .reset     (reset),
      .clear_all (clear_all),
      .rd_en     (bin_rd_en),
      .rd_addr   (bin_rd_addr),
      .rd_data   (bin_rd_data),
      .wr_en     (bin_wr_en),
      .wr_addr   (bin_addr_ff),
      .wr_data   (bin_wr_data)
   );

   esc_table_ram #(
      .DEPTH (MAX_STEP_CYCLES),
      .AW    (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (table_wr_en),
      .wr_addr (idx_ff),
      .wr_data (div_quotient[esc_pkg::POS_W-1:0]),
      .rd_en   (table_rd_en),
      .rd_addr (table_rd_addr),
      .rd_data (table_rd_data)
   );

   esc_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign busy       = (state_ff != ST_IDLE);
   assign req_accept = start && !busy;
   assign req_bin    = req_step_index[esc_pkg::STEP_W-1:2];

   // bin must be below the latched cycle count
   assign bin_in_range = 10'(req_bin) < 10'(cnt_ff);

   assign idx_next   = idx_ff + 1'b1;
   assign last_entry = (10'(idx_ff) + 10'd1) >= 10'(cnt_ff);

   // cycle count is steps per revolution over four, capped at the table depth
   assign spr_quarter  = spr_ff[esc_pkg::SPR_W-1:2];
   assign cnt_from_spr = (10'(spr_quarter) > 10'(MAX_STEP_CYCLES)) ?
                         CW'(MAX_STEP_CYCLES) : CW'(spr_quarter);

   // offset into the segment times 255, 32-bit wrap when the last entry catches a low reading
   assign diff   = esc_pkg::DIVIDEND_W'(r_ff) - esc_pkg::DIVIDEND_W'(cur_ff);
   assign scaled = (diff << 8) - diff;

   assign spr_in = csr_wr_en ? csr_wr_data : spr_ff;

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      bin_addr_in    = bin_addr_ff;
      cnt_in         = cnt_ff;
      table_valid_in = table_valid_ff;
      pos_in         = pos_ff;
      status_in      = status_ff;
      answer_in      = answer_ff;
      r_in           = r_ff;
      cur_in         = cur_ff;
      per_in         = per_ff;

      clear_all          = 1'b0;
      bin_rd_en          = 1'b0;
      bin_rd_addr        = idx_next;
      bin_wr_en          = 1'b0;
      bin_wr_data.sum    = bin_rd_data.sum + esc_pkg::SUM_W'(pos_ff);
      bin_wr_data.visits = bin_rd_data.visits + 1'b1;
      table_wr_en        = 1'b0;
      table_rd_en        = 1'b0;
      table_rd_addr      = idx_next;
      div_req.start      = 1'b0;
      div_req.dividend   = esc_pkg::DIVIDEND_W'(esc_pkg::FULL_SCALE);
      div_req.divisor    = esc_pkg::DIVISOR_W'(cnt_ff);

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               status_in   = esc_pkg::STAT_OK;
               answer_in   = '0;
               pos_in      = req_position;
               bin_addr_in = AW'(req_bin);
               idx_in      = '0;
               state_in    = ST_DONE;
               case (req_cmd)
                  esc_pkg::CMD_START: begin
                     // clear accumulators and latch the cycle count
                     clear_all      = 1'b1;
                     table_valid_in = 1'b0;
                     cnt_in         = cnt_from_spr;
                  end
                  esc_pkg::CMD_RECORD: begin
                     // only the first step of each cycle is kept
                     if (req_step_index[1:0] == 2'b00) begin
                        if (!bin_in_range) begin
                           status_in = esc_pkg::STAT_RANGE;
                        end else if (!((req_step_index == '0) &&
                                       (req_position > esc_pkg::HALF_SCALE))) begin
                           bin_rd_en   = 1'b1;
                           bin_rd_addr = AW'(req_bin);
                           state_in    = ST_REC_WR;
                        end
                     end
                  end
                  esc_pkg::CMD_FINALIZE: begin
                     table_valid_in = 1'b0;
                     if (cnt_ff == '0) begin
                        status_in = esc_pkg::STAT_EMPTY_BIN;
                     end else begin
                        bin_rd_en   = 1'b1;
                        bin_rd_addr = '0;
                        state_in    = ST_FIN_CHK;
                     end
                  end
                  default: begin
                     // query: cycle length first, then walk the table
                     if (!table_valid_ff) begin
                        status_in = esc_pkg::STAT_NOT_CAL;
                     end else if (cnt_ff != '0) begin
                        div_req.start = 1'b1;
                        state_in      = ST_Q_DIVN;
                     end
                  end
               endcase
            end
         end
         ST_REC_WR: begin
            // a full visit count ignores the sample
            if (bin_rd_data.visits < esc_pkg::VISIT_MAX) begin
               bin_wr_en = 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_FIN_CHK: begin
            if (bin_rd_data.visits == '0) begin
               status_in = esc_pkg::STAT_EMPTY_BIN;
               state_in  = ST_DONE;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = esc_pkg::DIVIDEND_W'(bin_rd_data.sum);
               div_req.divisor  = esc_pkg::DIVISOR_W'(bin_rd_data.visits);
               state_in         = ST_FIN_DIV;
            end
         end
         ST_FIN_DIV: begin
            if (div_done) begin
               table_wr_en = 1'b1;
               if (last_entry) begin
                  table_valid_in = 1'b1;
                  state_in       = ST_DONE;
               end else begin
                  idx_in    = idx_next;
                  bin_rd_en = 1'b1;
                  state_in  = ST_FIN_CHK;
               end
            end
         end
         ST_Q_DIVN: begin
            if (div_done) begin
               per_in        = div_quotient[esc_pkg::DIVISOR_W-1:0];
               table_rd_en   = 1'b1;
               table_rd_addr = '0;
               state_in      = ST_Q_FIRST;
            end
         end
         ST_Q_FIRST: begin
            // a reading below entry 0 wraps by a full revolution
            if (pos_ff < table_rd_data) begin
               r_in = esc_pkg::RNG_W'(pos_ff) + esc_pkg::FULL_SCALE;
            end else begin
               r_in = esc_pkg::RNG_W'(pos_ff);
            end
            cur_in   = table_rd_data;
            idx_in   = '0;
            state_in = ST_Q_STEP;
         end
         ST_Q_STEP: begin
            if (last_entry) begin
               state_in = ST_Q_MUL;
            end else begin
               table_rd_en = 1'b1;
               state_in    = ST_Q_CMP;
            end
         end
         ST_Q_CMP: begin
            if ((r_ff >= esc_pkg::RNG_W'(cur_ff)) &&
                (r_ff < esc_pkg::RNG_W'(table_rd_data))) begin
               state_in = ST_Q_MUL;
            end else begin
               cur_in   = table_rd_data;
               idx_in   = idx_next;
               state_in = ST_Q_STEP;
            end
         end
         ST_Q_MUL: begin
            div_req.start    = 1'b1;
            div_req.dividend = scaled;
            div_req.divisor  = per_ff;
            state_in         = ST_Q_DIV;
         end
         ST_Q_DIV: begin
            if (div_done) begin
               answer_in = div_quotient[esc_pkg::ANS_W-1:0];
               state_in  = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cnt_ff         <= CNT_RESET;
         spr_ff         <= esc_pkg::SPR_RESET;
         table_valid_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cnt_ff         <= cnt_in;
         spr_ff         <= spr_in;
         table_valid_ff <= table_valid_in;
      end
      idx_ff      <= idx_in;
      bin_addr_ff <= bin_addr_in;
      pos_ff      <= pos_in;
      status_ff   <= status_in;
      answer_ff   <= answer_in;
      r_ff        <= r_in;
      cur_ff      <= cur_in;
      per_ff      <= per_in;
   end

   assign rsp_strobe            = (state_ff == ST_DONE);
   assign rsp_position_in_cycle = answer_ff;
   assign rsp_status            = status_ff;

`ifndef SYNTH
   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> (!rsp_strobe && !busy))
      else $error("response strobe longer than one cycle");

   a_fail_zero_answer: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != esc_pkg::STAT_OK)) |-> (rsp_position_in_cycle == '0))
      else $error("failed request returned a nonzero answer");

   a_valid_from_finalize: assert property (@(posedge clock) disable iff (reset)
      $rose(table_valid_ff) |-> ($past(state_ff) == ST_FIN_DIV))
      else $error("table marked valid outside finalize");
`endif

endmodule

// ----- rtl/esc_divider.sv -----
// radix-2 restoring divider, one quotient bit per cycle
module esc_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  esc_pkg::div_req_type                req,
   output logic                                done,
   output logic [esc_pkg::DIVIDEND_W-1:0]      quotient
);

   localparam int CNT_W = $clog2(esc_pkg::DIVIDEND_W);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [CNT_W-1:0]                   cnt_ff, cnt_in;
   logic [esc_pkg::DIVISOR_W-1:0]      rem_ff, rem_in;
   logic [esc_pkg::DIVIDEND_W-1:0]     quo_ff, quo_in;
   logic [esc_pkg::DIVISOR_W-1:0]      dvs_ff, dvs_in;
   logic [esc_pkg::DIVISOR_W:0]        trial;
   logic [esc_pkg::DIVISOR_W:0]        diff;
   logic                               take;

   assign trial = {rem_ff, quo_ff[esc_pkg::DIVIDEND_W-1]};
   assign take  = trial >= {1'b0, dvs_ff};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(esc_pkg::DIVIDEND_W - 1);
         rem_in  = '0;
         quo_in  = req.dividend;
         dvs_in  = req.divisor;
      end else if (busy_ff) begin
         rem_in = take ? diff[esc_pkg::DIVISOR_W-1:0] : trial[esc_pkg::DIVISOR_W-1:0];
         quo_in = {quo_ff[esc_pkg::DIVIDEND_W-2:0], take};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- rtl/esc_bin_store.sv -----
// bin accumulator memory with per-entry valid bits, so a clear needs no walk over the entries
module esc_bin_store #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    clear_all,
   input  logic                    rd_en,
   input  logic [AW-1:0]           rd_addr,
   output esc_pkg::bin_entry_type  rd_data,
   input  logic                    wr_en,
   input  logic [AW-1:0]           wr_addr,
   input  esc_pkg::bin_entry_type  wr_data
);

   esc_pkg::bin_entry_type mem [DEPTH];
   esc_pkg::bin_entry_type data_ff;
   logic                   hit_ff;
   logic [DEPTH-1:0]       valid_ff, valid_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         data_ff <= mem[rd_addr];
         hit_ff  <= valid_ff[rd_addr];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (clear_all) begin
         valid_in = '0;
      end else if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // entries not written since the last clear read as zero
   assign rd_data = hit_ff ? data_ff : '0;

endmodule

// ----- rtl/esc_table_ram.sv -----
// cycle start table memory, one write and one registered read port
module esc_table_ram #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic [esc_pkg::POS_W-1:0]  wr_data,
   input  logic                       rd_en,
   input  logic [AW-1:0]              rd_addr,
   output logic [esc_pkg::POS_W-1:0]  rd_data
);

   logic [esc_pkg::POS_W-1:0] mem [DEPTH];
   logic [esc_pkg::POS_W-1:0] data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = data_ff;

endmodule

// ----- sim/tb_encoder_step_cycle_calibration.sv -----
// self-checking testbench of the encoder step-cycle calibration table
`timescale 1ns / 100ps

module tb_encoder_step_cycle_calibration;

   localparam int CYCLES_MAX    = 64;
   localparam int RANDOM_ITEMS  = 700;
   localparam int DIRECTED_ROWS = 27;

   // one accepted request leads to exactly one response
   typedef struct packed {
      logic [esc_pkg::CMD_W-1:0]  cmd;
      logic [esc_pkg::ANS_W-1:0]  answer;
      logic [esc_pkg::STAT_W-1:0] status;
   } calib_result_type;

   // directed rows either issue a request or rewrite steps per revolution
   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type               kind;
      logic [esc_pkg::CMD_W-1:0]  cmd;
      logic [esc_pkg::STEP_W-1:0] step;
      logic [esc_pkg::POS_W-1:0]  pos;
      logic [esc_pkg::SPR_W-1:0]  spr;
      logic                       typed;
      logic [esc_pkg::ANS_W-1:0]  answer;
      logic [esc_pkg::STAT_W-1:0] status;
   } dir_row_type;

   logic                         clock;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic [esc_pkg::CMD_W-1:0]    req_cmd;
   logic [esc_pkg::STEP_W-1:0]   req_step_index;
   logic [esc_pkg::POS_W-1:0]    req_position;
   logic                         rsp_strobe;
   logic [esc_pkg::ANS_W-1:0]    rsp_position_in_cycle;
   logic [esc_pkg::STAT_W-1:0]   rsp_status;
   logic                         csr_wr_en;
   logic [esc_pkg::SPR_W-1:0]    csr_wr_data;

   // shadow copy of the calibration state
   logic [esc_pkg::SUM_W-1:0]    acc_sum     [CYCLES_MAX];
   logic [esc_pkg::VISIT_W-1:0]  acc_visits  [CYCLES_MAX];
   logic [esc_pkg::POS_W-1:0]    cycle_start [CYCLES_MAX];
   logic                         table_ok;
   logic [esc_pkg::SPR_W-1:0]    spr_reg;
   logic [6:0]                   cycles_latched;

   calib_result_type pending_results[$];
   int mismatch_count;
   int counted_requests;
   int sender_idle_pct;
   bit bin_fill_done;

   // directed table: typed rows carry their response, the rest go through the predictor
   dir_row_type directed [DIRECTED_ROWS] = '{
      // fresh after reset: 50 bins latched, nothing calibrated
      '{ROW_REQ, esc_pkg::CMD_QUERY, 8'd0, 14'd16383, 9'd0, 1'b1, 8'd0, esc_pkg::STAT_NOT_CAL},
      '{ROW_REQ, esc_pkg::CMD_FINALIZE, 8'd0, 14'd0, 9'd0, 1'b1, 8'd0, esc_pkg::STAT_EMPTY_BIN},
      '{ROW_REQ, esc_pkg::CMD_RECORD, 8'd1, 14'd0, 9'd0, 1'b1, 8'd0, esc_pkg::STAT_OK},
      '{ROW_REQ, esc_pkg::CMD_RECORD, 8'd200, 14'd5, 9'd0, 1'b1, 8'd0, esc_pkg::STAT_RANGE},
      '{ROW_REQ, esc_pkg::CMD_RECORD, 8'd255, 14'd16383, 9'd0, 1'b1, 8'd0, esc_pkg::STAT_OK},
      '{ROW_REQ, esc_pkg::CMD_RECORD, 8'd252, 14'd0, 9'd0, 1'b1, 8'd0, esc_pkg::STAT_RANGE},
      '{ROW_REQ, esc_pkg::CMD_RECORD, 8'd0, 14'd16383, 9'd0, 1'b1, 8'd0, esc_pkg::STAT_OK},
      '{ROW_REQ, esc_pkg::CMD_RECORD, 8'd0, 14'd8192, 9'd0, 1'b1, 8'd0, esc_pkg::STAT_OK},
      // zero step cycles: every bin is out of range, finalize cannot succeed
      '{ROW_CSR, esc_pkg::CMD_START, 8'd0, 14'd0, 9'd0, 1'b0, 8'd0, esc_pkg::STAT_OK},
      '{ROW_REQ, esc_pkg::CMD_START, 8'd0, 14'd0, 9'd0, 1'b1, 8'd0, esc_pkg::STAT_OK},
      '{ROW_REQ, esc_pkg::CMD_FINALIZE, 8'd0, 14'd0, 9'd0, 1'b1, 8'd0, esc_pkg::STAT_EMPTY_BIN},
      '{ROW_REQ, esc_pkg::CMD_QUERY, 8'd0, 14'd0, 9'd0, 1'b1, 8'd0, esc_pkg::STAT_NOT_CAL},
      '{ROW_REQ, esc_pkg::CMD_RECORD, 8'd0, 14'd100, 9'd0, 1'b1, 8'd0, esc_pkg::STAT_RANGE},
      // two step cycles: empty second bin first, then a full table
      '{ROW_CSR, esc_pkg::CMD_START, 8'd0, 14'd0, 9'd8, 1'b0, 8'd0, esc_pkg::STAT_OK},
      '{ROW_REQ, esc_pkg::CMD_START, 8'd0, 14'd0, 9'd0, 1'b1, 8'd0, esc_pkg::STAT_OK},
      '{ROW_REQ, esc_pkg::CMD_RECORD, 8'd0, 14'd0, 9'd0, 1'b1, 8'd0, esc_pkg::STAT_OK},
      '{ROW_REQ, esc_pkg::CMD_FINALIZE, 8'd0, 14'd0, 9'd0, 1'b1, 8'd0, esc_pkg::STAT_EMPTY_BIN},
      '{ROW_REQ, esc_pkg::CMD_RECORD, 8'd4, 14'd16383, 9'd0, 1'b1, 8'd0, esc_pkg::STAT_OK},
      '{ROW_REQ, esc_pkg::CMD_RECORD, 8'd4, 14'd8191, 9'd0, 1'b1, 8'd0, esc_pkg::STAT_OK},
      '{ROW_REQ, esc_pkg::CMD_FINALIZE, 8'd0, 14'd0, 9'd0, 1'b1, 8'd0, esc_pkg::STAT_OK},
      '{ROW_REQ, esc_pkg::CMD_QUERY, 8'd0, 14'd0, 9'd0, 1'b0, 8'd0, esc_pkg::STAT_OK},
      '{ROW_REQ, esc_pkg::CMD_QUERY, 8'd0, 14'd16383, 9'd0, 1'b0, 8'd0, esc_pkg::STAT_OK},
      '{ROW_REQ, esc_pkg::CMD_QUERY, 8'd0, 14'd12287, 9'd0, 1'b0, 8'd0, esc_pkg::STAT_OK},
      '{ROW_REQ, esc_pkg::CMD_QUERY, 8'd0, 14'd12286, 9'd0, 1'b0, 8'd0, esc_pkg::STAT_OK},
      // widest register value, capped at the table size; start drops the table
      '{ROW_CSR, esc_pkg::CMD_START, 8'd0, 14'd0, 9'd511, 1'b0, 8'd0, esc_pkg::STAT_OK},
      '{ROW_REQ, esc_pkg::CMD_START, 8'd0, 14'd0, 9'd0, 1'b1, 8'd0, esc_pkg::STAT_OK},
      '{ROW_REQ, esc_pkg::CMD_QUERY, 8'd0, 14'd100, 9'd0, 1'b1, 8'd0, esc_pkg::STAT_NOT_CAL}
   };

   encoder_step_cycle_calibration #(
      .MAX_STEP_CYCLES(CYCLES_MAX)
   ) DUT (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_cmd              (req_cmd),
      .req_step_index       (req_step_index),
      .req_position         (req_position),
      .rsp_strobe           (rsp_strobe),
      .rsp_position_in_cycle(rsp_position_in_cycle),
      .rsp_status           (rsp_status),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data)
   );

   // 10 ns clock
   always #5 clock = ~clock;

   // step cycles latched at start: a quarter of the steps, capped at the table size
   function automatic logic [6:0] step_cycles_of(input logic [esc_pkg::SPR_W-1:0] spr);
      logic [6:0] n;
      n = spr[esc_pkg::SPR_W-1:2];
      if (n > 7'(CYCLES_MAX))
         n = 7'(CYCLES_MAX);
      return n;
   endfunction

   // predicts the response of one request and advances the shadow state
   function automatic void predict_calibration(input logic [esc_pkg::CMD_W-1:0] cmd,
                                               input logic [esc_pkg::STEP_W-1:0] step,
                                               input logic [esc_pkg::POS_W-1:0] pos,
                                               output logic [esc_pkg::ANS_W-1:0] answer,
                                               output logic [esc_pkg::STAT_W-1:0] status);
      logic [5:0]                bin;
      logic [esc_pkg::SUM_W-1:0] mean;
      logic [31:0]               reading, base, diff, product, per_cycle;
      bit                        done;
      answer = '0;
      status = esc_pkg::STAT_OK;
      done   = 1'b0;
      case (cmd)
         esc_pkg::CMD_START: begin
            for (int i = 0; i < CYCLES_MAX; i++) begin
               acc_sum[i]    = '0;
               acc_visits[i] = '0;
            end
            table_ok       = 1'b0;
            cycles_latched = step_cycles_of(spr_reg);
         end
         esc_pkg::CMD_RECORD: begin
            // only the first step of each cycle is kept
            if (step[1:0] == 2'b00) begin
               bin = step[esc_pkg::STEP_W-1:2];
               if (7'(bin) >= cycles_latched)
                  status = esc_pkg::STAT_RANGE;
               else if (!(step == 0 && pos > esc_pkg::HALF_SCALE) &&
                        acc_visits[bin] != esc_pkg::VISIT_MAX) begin
                  acc_sum[bin]    = acc_sum[bin] + esc_pkg::SUM_W'(pos);
                  acc_visits[bin] = acc_visits[bin] + 1'b1;
               end
            end
         end
         esc_pkg::CMD_FINALIZE: begin
            table_ok = 1'b0;
            if (cycles_latched == 0)
               status = esc_pkg::STAT_EMPTY_BIN;
            else begin
               // stop at the first bin nobody visited
               for (int i = 0; i < cycles_latched; i++) begin
                  if (!done) begin
                     if (acc_visits[i] == 0)
                        done = 1'b1;
                     else begin
                        mean           = acc_sum[i] / esc_pkg::SUM_W'(acc_visits[i]);
                        cycle_start[i] = mean[esc_pkg::POS_W-1:0];
                     end
                  end
               end
               if (done)
                  status = esc_pkg::STAT_EMPTY_BIN;
               else
                  table_ok = 1'b1;
            end
         end
         default: begin
            if (!table_ok)
               status = esc_pkg::STAT_NOT_CAL;
            else begin
               per_cycle = 32'd16384 / 32'(cycles_latched);
               reading   = {18'd0, pos};
               // readings below the first entry belong to the previous turn
               if (reading < {18'd0, cycle_start[0]})
                  reading = reading + 32'(esc_pkg::FULL_SCALE);
               for (int i = 0; i < cycles_latched; i++) begin
                  if (!done && (i + 1 >= cycles_latched ||
                      (reading >= {18'd0, cycle_start[i]} &&
                       reading < {18'd0, cycle_start[i+1]}))) begin
                     base    = {18'd0, cycle_start[i]};
                     diff    = reading - base;
                     product = diff * 32'd255;
                     product = product / per_cycle;
                     answer  = product[esc_pkg::ANS_W-1:0];
                     done    = 1'b1;
                  end
               end
            end
         end
      endcase
   endfunction

   task automatic flag_mismatch(input string field, input logic [esc_pkg::CMD_W-1:0] cmd,
                                input int want, input int got);
      if (mismatch_count < 200)
         $display("%0t ns: cmd %0d %s expected %0d got %0d", $time, cmd, field, want, got);
      mismatch_count++;
   endtask

   // presents one request, holds it until the block takes it, then queues the prediction
   task automatic send_request(input logic [esc_pkg::CMD_W-1:0] cmd,
                               input logic [esc_pkg::STEP_W-1:0] step,
                               input logic [esc_pkg::POS_W-1:0] pos, input logic typed,
                               input logic [esc_pkg::ANS_W-1:0] t_answer,
                               input logic [esc_pkg::STAT_W-1:0] t_status);
      calib_result_type predicted;
      int gap;
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         start <= 1'b0;
         gap = $urandom_range(1, 6);
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_cmd        <= cmd;
      req_step_index <= step;
      req_position   <= pos;
      do @(posedge clock); while (busy);
      // taken at this edge
      predicted.cmd = cmd;
      predict_calibration(cmd, step, pos, predicted.answer, predicted.status);
      if (typed) begin
         predicted.answer = t_answer;
         predicted.status = t_status;
      end
      pending_results.push_back(predicted);
      // records on a step other than a cycle start are simply ignored
      if (!(cmd == esc_pkg::CMD_RECORD && step[1:0] != 2'b00))
         counted_requests++;
   endtask

   task automatic issue(input logic [esc_pkg::CMD_W-1:0] cmd,
                        input logic [esc_pkg::STEP_W-1:0] step,
                        input logic [esc_pkg::POS_W-1:0] pos);
      send_request(cmd, step, pos, 1'b0, '0, esc_pkg::STAT_OK);
   endtask

   // drop start and wait for the last response and for busy to clear
   task automatic wait_until_idle();
      start <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0 || busy) @(posedge clock);
   endtask

   task automatic write_steps_per_rev(input logic [esc_pkg::SPR_W-1:0] value);
      wait_until_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      spr_reg      = value;
   endtask

   // out-of-sequence traffic mixed into the well-formed calibration flow
   task automatic maybe_noise();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 8)
         issue(esc_pkg::CMD_RECORD, 8'($urandom_range(0, 255)), 14'($urandom_range(0, 16383)));
      else if (roll < 10)
         issue(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
               14'($urandom_range(0, 16383)));
   endtask

   // one calibration pass: new register value, start, samples per bin, finalize, queries
   task automatic run_calibration_pass(input bit fill_bin);
      logic [esc_pkg::SPR_W-1:0] spr;
      int n, per, jit, offset, skip_bin, samples, queries, pick;
      case ($urandom_range(0, 9))
         0:       spr = 9'($urandom_range(0, 511));
         1:       spr = 9'($urandom_range(200, 256));
         default: spr = 9'($urandom_range(4, 48));
      endcase
      // one bin taking more samples than its visit counter holds
      if (fill_bin)
         spr = 9'($urandom_range(4, 7));
      write_steps_per_rev(spr);

      // the new value must not reach the old table before the next start
      if ($urandom_range(0, 4) == 0)
         repeat ($urandom_range(1, 3))
            issue(esc_pkg::CMD_QUERY, '0, 14'($urandom_range(0, 16383)));

      issue(esc_pkg::CMD_START, 8'($urandom_range(0, 255)), 14'($urandom_range(0, 16383)));
      n        = int'(step_cycles_of(spr));
      per      = 16384 / (n == 0 ? 1 : n);
      jit      = per / 8 < 190 ? per / 8 : 190;
      offset   = $urandom_range(0, 8000);
      skip_bin = (n > 0 && $urandom_range(0, 7) == 0) ? $urandom_range(0, n - 1) : -1;

      for (int b = 0; b < n; b++) begin
         if (b != skip_bin) begin
            samples = fill_bin ? 258 : $urandom_range(1, 3);
            for (int k = 0; k < samples; k++) begin
               maybe_noise();
               issue(esc_pkg::CMD_RECORD, 8'(b * 4),
                     14'((offset + b * per + $urandom_range(0, jit)) % 16384));
            end
         end
      end
      // a step 0 sample from the upper half of the turn gets dropped
      if ($urandom_range(0, 3) == 0)
         issue(esc_pkg::CMD_RECORD, 8'd0, 14'($urandom_range(8193, 16383)));

      issue(esc_pkg::CMD_FINALIZE, 8'($urandom_range(0, 255)), 14'($urandom_range(0, 16383)));
      if ($urandom_range(0, 5) == 0)
         issue(esc_pkg::CMD_FINALIZE, '0, '0);

      queries = $urandom_range(4, 16);
      for (int q = 0; q < queries; q++) begin
         maybe_noise();
         if ($urandom_range(0, 3) == 0 && n > 0) begin
            // readings close to a segment boundary
            pick = $urandom_range(0, n - 1);
            issue(esc_pkg::CMD_QUERY, 8'($urandom_range(0, 255)),
                  14'((offset + pick * per + $urandom_range(0, jit + 2) + 16383) % 16384));
         end else
            issue(esc_pkg::CMD_QUERY, 8'($urandom_range(0, 255)),
                  14'($urandom_range(0, 16383)));
      end
   endtask

   // response checker: every strobe is matched against the oldest prediction
   always @(posedge clock) begin : check_responses
      calib_result_type oldest;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0)
            flag_mismatch("unexpected response, status", '0, -1, int'(rsp_status));
         else begin
            oldest = pending_results.pop_front();
            if (rsp_position_in_cycle !== oldest.answer)
               flag_mismatch("position_in_cycle", oldest.cmd, int'(oldest.answer),
                             int'(rsp_position_in_cycle));
            if (rsp_status !== oldest.status)
               flag_mismatch("status", oldest.cmd, int'(oldest.status), int'(rsp_status));
         end
      end
   end

   // stimulus
   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      start            = 1'b0;
      req_cmd          = esc_pkg::CMD_START;
      req_step_index   = '0;
      req_position     = '0;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      mismatch_count   = 0;
      counted_requests = 0;
      sender_idle_pct  = 37;
      bin_fill_done    = 1'b0;

      // shadow state after reset
      for (int i = 0; i < CYCLES_MAX; i++) begin
         acc_sum[i]     = '0;
         acc_visits[i]  = '0;
         cycle_start[i] = '0;
      end
      table_ok       = 1'b0;
      spr_reg        = esc_pkg::SPR_RESET;
      cycles_latched = step_cycles_of(esc_pkg::SPR_RESET);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed part
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         if (directed[r].kind == ROW_CSR)
            write_steps_per_rev(directed[r].spr);
         else
            send_request(directed[r].cmd, directed[r].step, directed[r].pos,
                         directed[r].typed, directed[r].answer, directed[r].status);
      end

      // random part: sender idles 37 percent, then 45 percent, then never
      counted_requests = 0;
      while (counted_requests < RANDOM_ITEMS) begin
         if (counted_requests < RANDOM_ITEMS / 3)
            sender_idle_pct = 37;
         else if (counted_requests < 2 * RANDOM_ITEMS / 3)
            sender_idle_pct = 45;
         else
            sender_idle_pct = 0;
         if (!bin_fill_done && counted_requests > 300) begin
            run_calibration_pass(1'b1);
            bin_fill_done = 1'b1;
         end else
            run_calibration_pass(1'b0);
      end

      // drain, then keep the clock running to catch stray strobes
      wait_until_idle();
      repeat (50) @(posedge clock);
      if (mismatch_count == 0)
         $display("encoder_step_cycle_calibration: match");
      else
         $display("encoder_step_cycle_calibration: mismatch");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #100_000_000;
      $display("encoder_step_cycle_calibration: mismatch");
      $finish;
   end

endmodule
